// ===== design/lts_pkg.sv =====
// ----------------------------------------------------------------------------
// lts_pkg: shared types and constants of the lexical token scanner
// Token kinds, scan modes, the keyword spelling table and character classes.
// ----------------------------------------------------------------------------
package lts_pkg;

  localparam int MAX_TEXT_DEF = 1024;

  // Token kinds as they appear on the result channel.
  localparam logic [2:0] KIND_KEYWORD = 3'd0;
  localparam logic [2:0] KIND_IDENT   = 3'd1;
  localparam logic [2:0] KIND_INT     = 3'd2;
  localparam logic [2:0] KIND_DECIMAL = 3'd3;
  localparam logic [2:0] KIND_OPER    = 3'd4;
  localparam logic [2:0] KIND_COMMENT = 3'd5;
  localparam logic [2:0] KIND_UNKNOWN = 3'd6;
  localparam logic [2:0] KIND_END     = 3'd7;

  // Scan modes.
  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_IDENT   = 3'd1;
  localparam logic [2:0] MODE_INT     = 3'd2;
  localparam logic [2:0] MODE_DOT     = 3'd3;
  localparam logic [2:0] MODE_FRAC    = 3'd4;
  localparam logic [2:0] MODE_COMMENT = 3'd5;
  localparam logic [2:0] MODE_HELD    = 3'd6;

  localparam int NUM_KW = 6;

  // Keyword spellings, zero padded to eight characters.
  localparam logic [7:0] KW_CHARS [NUM_KW][8] = '{
    '{8'h69, 8'h6e, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // int
    '{8'h66, 8'h6c, 8'h6f, 8'h61, 8'h74, 8'h00, 8'h00, 8'h00},  // float
    '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // if
    '{8'h65, 8'h6c, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},  // else
    '{8'h77, 8'h68, 8'h69, 8'h6c, 8'h65, 8'h00, 8'h00, 8'h00},  // while
    '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6e, 8'h00, 8'h00}   // return
  };
  localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd3, 3'd5, 3'd2, 3'd4, 3'd5, 3'd6};

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  kw;
    logic [9:0]  start;
    logic [10:0] len;
    logic [7:0]  sym;
    logic        last;
  } tok_rec_t;

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b == 8'h20 || (b >= 8'h09 && b <= 8'h0d);
  endfunction

  // Bytes held as lookahead until the next byte: / = < >
  function automatic logic is_held_op(input logic [7:0] b);
    return b == 8'h2f || b == 8'h3d || b == 8'h3c || b == 8'h3e;
  endfunction

  // Single-byte operators: + - * ( )
  function automatic logic is_plain_op(input logic [7:0] b);
    return b == 8'h2b || b == 8'h2d || b == 8'h2a || b == 8'h28 || b == 8'h29;
  endfunction

endpackage

// ===== design/lexical_token_scanner.sv =====
// ----------------------------------------------------------------------------
// lexical_token_scanner: byte-stream tokenizer
// An item's results enter the output queue at the accepting edge and are
// offered from the queue registers. Throughput: one byte per cycle while each
// byte causes at most one record and the output keeps up; two-record bytes
// drain one record per cycle through the four-entry output queue. Reset
// (synchronous, active low) clears the scan state, position counter and queue.
// ----------------------------------------------------------------------------
module lexical_token_scanner
  import lts_pkg::*;
#(
  parameter int MAX_TEXT = MAX_TEXT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  input  logic        in_end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_token_kind,
  output logic [2:0]  out_keyword_number,
  output logic [9:0]  out_start_position,
  output logic [10:0] out_token_length,
  output logic [7:0]  out_symbol_byte,
  output logic        out_last_of_text
);

  // Positions wrap modulo MAX_TEXT; lengths saturate at MAX_TEXT.
  localparam int POS_W = $clog2(MAX_TEXT);
  localparam int LEN_W = $clog2(MAX_TEXT + 1);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_TEXT - 1);
  localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_TEXT);

  // Output queue geometry.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // --------------------------------------------------------------------------
  // Scan state. The held lookahead byte is only meaningful in the held mode,
  // which therefore also stands for the held-valid flag.
  // --------------------------------------------------------------------------
  logic [2:0]        mode_r,  mode_nxt;
  logic [POS_W-1:0]  pos_r,   pos_nxt;
  logic [POS_W-1:0]  start_r, start_nxt;
  logic [NUM_KW-1:0] kw_r,    kw_nxt;
  logic [7:0]        hb_r,    hb_nxt;
  logic [LEN_W-1:0]  len_r,   len_nxt;

  // Output queue.
  tok_rec_t          q_r [QDEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] cnt_r,  cnt_nxt;

  logic in_fire, out_fire;

  // Records produced by one transfer: a record that closes the pending token,
  // then possibly a second one (a new single-byte token, the end record, or a
  // two-byte operator).
  logic     do_flush, do_start;
  logic     fl_v, sec_v;
  tok_rec_t fl_rec, sec_rec, st_rec;
  logic     st_v;
  logic [2:0]        st_mode;
  logic [NUM_KW-1:0] st_kw;
  logic [NUM_KW-1:0] cont_kw;
  logic [LEN_W-1:0]  len_inc;
  logic [POS_W-1:0]  pos_inc;
  logic     push0_v, push1_v;
  tok_rec_t push0, push1;
  logic [7:0] b;

  assign b        = in_text_byte;
  assign in_ready = (cnt_r <= QCNT_W'(QDEPTH - 2));
  assign in_fire  = in_valid && in_ready;
  assign out_valid = (cnt_r != '0);
  assign out_fire  = out_valid && out_ready;

  assign len_inc = (len_r < LEN_MAX) ? len_r + 1'b1 : len_r;
  assign pos_inc = (pos_r == POS_LAST) ? '0 : pos_r + 1'b1;

  // Keyword tracking: a continuing word keeps a keyword alive only while the
  // byte at the current offset agrees; a new word starts from the first byte.
  always_comb begin
    for (int k = 0; k < NUM_KW; k++) begin
      cont_kw[k] = kw_r[k] && (len_r < LEN_W'(KW_LEN[k]))
                   && (KW_CHARS[k][len_r[2:0]] == b);
      st_kw[k]   = (KW_CHARS[k][0] == b);
    end
  end

  // Record that closes the pending token, taken from the current state.
  always_comb begin
    fl_v   = 1'b0;
    fl_rec = '{kind: KIND_IDENT, kw: 3'd0, start: 10'(start_r), len: 11'(len_r),
               sym: 8'd0, last: 1'b0};
    case (mode_r)
      MODE_IDENT: begin
        fl_v = 1'b1;
        // The lowest numbered keyword that still matches at its exact length wins.
        for (int k = NUM_KW - 1; k >= 0; k--) begin
          if (kw_r[k] && len_r == LEN_W'(KW_LEN[k])) begin
            fl_rec.kind = KIND_KEYWORD;
            fl_rec.kw   = 3'(k);
          end
        end
      end
      MODE_INT: begin
        fl_v = 1'b1;
        fl_rec.kind = KIND_INT;
      end
      MODE_FRAC: begin
        fl_v = 1'b1;
        fl_rec.kind = KIND_DECIMAL;
      end
      MODE_COMMENT: begin
        fl_v = 1'b1;
        fl_rec.kind = KIND_COMMENT;
      end
      MODE_HELD: begin
        fl_v = 1'b1;
        fl_rec.kind = KIND_OPER;
        fl_rec.len  = 11'd1;
        fl_rec.sym  = hb_r;
      end
      default: begin
        // Idle or a dangling dot: nothing to report.
        fl_v = 1'b0;
      end
    endcase
  end

  // Starting a token on the current byte. Plain operators and unknown bytes
  // are complete at once; the others open a mode.
  always_comb begin
    st_v    = 1'b0;
    st_mode = MODE_IDLE;
    st_rec  = '{kind: KIND_UNKNOWN, kw: 3'd0, start: 10'(pos_r), len: 11'd1,
                sym: b, last: 1'b0};
    if (is_space(b)) begin
      st_mode = MODE_IDLE;
    end else if (is_alpha(b)) begin
      st_mode = MODE_IDENT;
    end else if (is_digit(b)) begin
      st_mode = MODE_INT;
    end else if (b == 8'h2e) begin
      st_mode = MODE_DOT;
    end else if (is_held_op(b)) begin
      st_mode = MODE_HELD;
    end else if (is_plain_op(b)) begin
      st_v = 1'b1;
      st_rec.kind = KIND_OPER;
    end else begin
      st_v = 1'b1;
    end
  end

  // Next scan state and the records of this transfer.
  always_comb begin
    mode_nxt  = mode_r;
    pos_nxt   = pos_inc;
    start_nxt = start_r;
    kw_nxt    = kw_r;
    hb_nxt    = hb_r;
    len_nxt   = len_r;
    do_flush  = 1'b0;
    do_start  = 1'b0;
    sec_v     = 1'b0;
    sec_rec   = st_rec;

    if (in_end_of_text) begin
      // Close whatever is pending, then the end record; positions restart.
      do_flush = 1'b1;
      sec_v    = 1'b1;
      sec_rec  = '{kind: KIND_END, kw: 3'd0, start: 10'(pos_r), len: 11'd0,
                   sym: 8'd0, last: 1'b1};
    end else begin
      case (mode_r)
        MODE_IDENT: begin
          if (is_alpha(b) || is_digit(b)) begin
            kw_nxt  = cont_kw;
            len_nxt = len_inc;
          end else begin
            do_flush = 1'b1;
            do_start = 1'b1;
          end
        end
        MODE_INT: begin
          if (is_digit(b)) begin
            len_nxt = len_inc;
          end else if (b == 8'h2e) begin
            len_nxt  = len_inc;
            mode_nxt = MODE_DOT;
          end else begin
            do_flush = 1'b1;
            do_start = 1'b1;
          end
        end
        MODE_DOT: begin
          if (is_digit(b)) begin
            len_nxt  = len_inc;
            mode_nxt = MODE_FRAC;
          end else begin
            // A number ending on its dot is dropped without a record.
            do_start = 1'b1;
          end
        end
        MODE_FRAC: begin
          if (is_digit(b)) begin
            len_nxt = len_inc;
          end else begin
            do_flush = 1'b1;
            do_start = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (b == 8'h0a) begin
            do_flush = 1'b1;
          end else begin
            len_nxt = len_inc;
          end
        end
        MODE_HELD: begin
          if (hb_r == 8'h2f && b == 8'h2f) begin
            // Comment opener: the text begins after the second slash.
            hb_nxt    = 8'd0;
            start_nxt = pos_inc;
            len_nxt   = '0;
            mode_nxt  = MODE_COMMENT;
          end else if (hb_r != 8'h2f && b == 8'h3d) begin
            sec_v    = 1'b1;
            sec_rec  = '{kind: KIND_OPER, kw: 3'd0, start: 10'(start_r), len: 11'd2,
                         sym: hb_r, last: 1'b0};
            hb_nxt   = 8'd0;
            mode_nxt = MODE_IDLE;
          end else begin
            do_flush = 1'b1;
            do_start = 1'b1;
          end
        end
        default: begin
          do_start = 1'b1;
        end
      endcase
    end

    if (do_flush) begin
      mode_nxt = MODE_IDLE;
      hb_nxt   = 8'd0;
    end

    if (do_start) begin
      sec_v    = st_v;
      mode_nxt = st_mode;
      if (!is_space(b)) begin
        start_nxt = pos_r;
        len_nxt   = '0;
        if (st_mode == MODE_IDENT) begin
          kw_nxt  = st_kw;
          len_nxt = LEN_W'(1);
        end else if (st_mode == MODE_INT || st_mode == MODE_DOT) begin
          len_nxt = LEN_W'(1);
        end else if (st_mode == MODE_HELD) begin
          hb_nxt = b;
        end
      end
    end

    if (in_end_of_text) begin
      mode_nxt  = MODE_IDLE;
      pos_nxt   = '0;
      start_nxt = '0;
      kw_nxt    = '1;
      hb_nxt    = 8'd0;
      len_nxt   = '0;
    end
  end

  // Pack the records of this transfer into consecutive queue slots.
  always_comb begin
    push0_v = 1'b0;
    push1_v = 1'b0;
    push0   = sec_rec;
    push1   = sec_rec;
    if (do_flush && fl_v) begin
      push0_v = 1'b1;
      push0   = fl_rec;
      push1_v = sec_v;
    end else begin
      push0_v = sec_v;
    end
  end

  // Queue pointers: up to two writes and one read per cycle.
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (in_fire) begin
      wptr_nxt = wptr_r + QPTR_W'(push0_v) + QPTR_W'(push1_v);
      cnt_nxt  = cnt_r + QCNT_W'(push0_v) + QCNT_W'(push1_v);
    end
    if (out_fire) begin
      rptr_nxt = rptr_r + 1'b1;
      cnt_nxt  = cnt_nxt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      pos_r   <= '0;
      start_r <= '0;
      kw_r    <= '1;
      hb_r    <= 8'd0;
      len_r   <= '0;
      wptr_r  <= '0;
      rptr_r  <= '0;
      cnt_r   <= '0;
    end else begin
      if (in_fire) begin
        mode_r  <= mode_nxt;
        pos_r   <= pos_nxt;
        start_r <= start_nxt;
        kw_r    <= kw_nxt;
        hb_r    <= hb_nxt;
        len_r   <= len_nxt;
      end
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Queue storage holds payload only.
  always_ff @(posedge clk) begin
    if (in_fire && push0_v) begin
      q_r[wptr_r] <= push0;
    end
    if (in_fire && push1_v) begin
      q_r[wptr_r + 1'b1] <= push1;
    end
  end

  assign out_token_kind     = q_r[rptr_r].kind;
  assign out_keyword_number = q_r[rptr_r].kw;
  assign out_start_position = q_r[rptr_r].start;
  assign out_token_length   = q_r[rptr_r].len;
  assign out_symbol_byte    = q_r[rptr_r].sym;
  assign out_last_of_text   = q_r[rptr_r].last;

endmodule
